FILE: design/cia_pkg.sv
// shared types and codes for the circular identifier allocator
package cia_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_NOT_BUSY  = 2'd2
    } status_t;

    typedef struct packed {
        logic       cmd;
        logic [4:0] id_to_free;
    } req_t;

    typedef struct packed {
        logic [4:0] granted_id;
        status_t    status;
    } rsp_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FREE
    } fsm_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic grant;
        logic exhaust;
        logic free_done;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic probe_busy;
        logic last_try;
    } dp_stat_t;

endpackage

FILE: design/cia_ctrl.sv
// controller state machine for the circular identifier allocator
module cia_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd,
    input  cia_pkg::dp_stat_t   stat,
    output cia_pkg::dp_ctrl_t   ctrl,
    output logic                busy
);

    cia_pkg::fsm_state_t state_reg;
    cia_pkg::fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cia_pkg::FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cia_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd == cia_pkg::CMD_FREE) ? cia_pkg::FSM_FREE
                                                            : cia_pkg::FSM_SCAN;
                end
            end
            cia_pkg::FSM_SCAN:
            begin
                if (!stat.probe_busy || stat.last_try)
                begin
                    state_next = cia_pkg::FSM_IDLE;
                end
            end
            cia_pkg::FSM_FREE:
            begin
                state_next = cia_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = cia_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            cia_pkg::FSM_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            cia_pkg::FSM_SCAN:
            begin
                if (!stat.probe_busy)
                begin
                    ctrl.grant = 1'b1;
                end
                else if (stat.last_try)
                begin
                    ctrl.exhaust = 1'b1;
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            cia_pkg::FSM_FREE:
            begin
                ctrl.free_done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: design/cia_datapath.sv
// busy map, next pointer, scan candidate and result register
module cia_datapath #(
    parameter int NUM_IDS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cia_pkg::req_t       req,
    input  cia_pkg::dp_ctrl_t   ctrl,
    output cia_pkg::dp_stat_t   stat,
    output logic                done,
    output cia_pkg::rsp_t       result
);

    localparam int IDW = (NUM_IDS > 2) ? $clog2(NUM_IDS) : 1;
    localparam int CW  = (IDW > 5) ? IDW : 5;
    localparam logic [IDW-1:0] LAST_ID = IDW'(NUM_IDS - 1);

    logic [NUM_IDS-1:0] busy_map_reg;
    logic [IDW-1:0]     next_ptr_reg;
    logic [IDW-1:0]     cand_reg;
    logic [IDW-1:0]     count_reg;
    logic [4:0]         free_id_reg;
    logic               done_reg;
    cia_pkg::rsp_t      rsp_reg;

    logic [CW-1:0]      free_ext;
    logic [CW-1:0]      cand_ext;
    logic               free_in_range;
    logic [IDW-1:0]     free_idx;
    logic [IDW-1:0]     cand_wrap;
    logic               free_busy;

    assign free_ext      = CW'(free_id_reg);
    assign cand_ext      = CW'(cand_reg);
    assign free_in_range = free_ext <= CW'(NUM_IDS - 1);
    assign free_idx      = free_in_range ? free_ext[IDW-1:0] : '0;
    assign free_busy     = free_in_range && busy_map_reg[free_idx];
    assign cand_wrap     = (cand_reg == LAST_ID) ? '0 : cand_reg + 1'b1;

    // scan probes the candidate
    assign stat.probe_busy = busy_map_reg[cand_reg];
    assign stat.last_try   = (count_reg == LAST_ID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_map_reg <= '0;
            next_ptr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.grant | ctrl.exhaust | ctrl.free_done;
            if (ctrl.grant)
            begin
                busy_map_reg[cand_reg] <= 1'b1;
                next_ptr_reg           <= cand_wrap;
            end
            if (ctrl.free_done && free_busy)
            begin
                busy_map_reg[free_idx] <= 1'b0;
                if (free_idx < next_ptr_reg)
                begin
                    next_ptr_reg <= free_idx;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            free_id_reg <= req.id_to_free;
            cand_reg    <= next_ptr_reg;
            count_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            cand_reg  <= cand_wrap;
            count_reg <= count_reg + 1'b1;
        end

        if (ctrl.grant)
        begin
            rsp_reg.granted_id <= cand_ext[4:0];
            rsp_reg.status     <= cia_pkg::STAT_OK;
        end
        else if (ctrl.exhaust)
        begin
            rsp_reg.granted_id <= '0;
            rsp_reg.status     <= cia_pkg::STAT_EXHAUSTED;
        end
        else if (ctrl.free_done)
        begin
            rsp_reg.granted_id <= '0;
            rsp_reg.status     <= free_busy ? cia_pkg::STAT_OK : cia_pkg::STAT_NOT_BUSY;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

FILE: design/circular_id_allocator_top.sv
// top level of the circular identifier allocator
//
//   channel   signals            direction  handshake
//   request   start, busy, req   in         taken when start high and busy low
//   result    done, result       out        one-cycle strobe, no back-pressure
//
// an allocate probes k identifiers (1 to NUM_IDS) in the one-probe-per-cycle
// scan of the busy map; a free needs no scan;
// busy stays high until the result strobes
// reset clears the busy map and the next pointer at once, no sweep
// results cannot be stalled, so no request is held waiting on the output
module circular_id_allocator_top #(
    parameter int NUM_IDS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cia_pkg::req_t   req,
    output logic            busy,
    output logic            done,
    output cia_pkg::rsp_t   result
);

    cia_pkg::dp_ctrl_t ctrl;
    cia_pkg::dp_stat_t stat;

    cia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    cia_datapath #(
        .NUM_IDS (NUM_IDS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .ctrl   (ctrl),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

FILE: design/cia_checker.sv
// port checker for the circular identifier allocator, bound to the top level
module cia_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic            done,
    input  cia_pkg::rsp_t   result
);

    // a taken request always makes the block busy in the cycle after it
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy not raised");

    // the block frees up exactly when its result strobes
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == cia_pkg::STAT_OK ||
                  result.status == cia_pkg::STAT_EXHAUSTED ||
                  result.status == cia_pkg::STAT_NOT_BUSY))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != cia_pkg::STAT_OK) |-> (result.granted_id == 5'd0))
        else $error("failed request returned a nonzero identifier");

endmodule

bind circular_id_allocator_top cia_checker u_cia_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
